@@ rtl/acfc_pkg.sv @@
// Shared types, constants and functions of the ASCII frame CRC-32 checker.
`default_nettype none

package acfc_pkg;

   // Widths of the item fields and the configuration port.
   localparam int BYTE_W   = 8;
   localparam int STATUS_W = 2;
   localparam int LEN_W    = 14;
   localparam int CRC_W    = 32;
   localparam int CSR_IDX_W = 8;

   // Tail held back from the CRC: separator plus eight hex digits.
   localparam int TAIL_LEN  = 9;
   localparam int FILL_W    = 4;
   localparam int HEX_DIGITS = 8;

   // Reflected CRC-32 polynomial.
   localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;

   // Reset values of the configuration registers.
   localparam logic [BYTE_W-1:0] START_CHAR_RESET = 8'h23;
   localparam logic [BYTE_W-1:0] END_CHAR_RESET   = 8'h0D;

   // Depth of the queue between front and back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_START_CHAR = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_END_CHAR   = 8'd1;

   // Result kinds.
   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   // Frame verdicts.
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_MISMATCH = 2'd1,
      STATUS_SHORT    = 2'd2,
      STATUS_OVERFLOW = 2'd3
   } status_type;

   // Operations passed from the front to the back.
   typedef enum logic [1:0] {
      OP_START = 2'd0,
      OP_DATA  = 2'd1,
      OP_END   = 2'd2
   } op_type;

   // One queued command.
   typedef struct packed {
      op_type            op;
      logic [BYTE_W-1:0] data;
   } cmd_type;

   // One reflected CRC-32 step over a byte.
   function automatic logic [CRC_W-1:0] crc32_byte(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
      logic [CRC_W-1:0] v;
      v = {24'h000000, crc[7:0] ^ b};
      for (int k = 0; k < 8; k++) begin
         v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
      end
      return {8'h00, crc[31:8]} ^ v;
   endfunction

   // Lowercase ASCII hex digit of a nibble.
   function automatic logic [BYTE_W-1:0] hex_lower(input logic [3:0] n);
      logic [BYTE_W-1:0] r;
      if (n < 4'd10) begin
         r = 8'h30 + {4'h0, n};
      end else begin
         r = 8'h57 + {4'h0, n};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

@@ rtl/acfc_front.sv @@
// Front end: configuration registers, start/end hunting and command issue.
`default_nettype none

module acfc_front (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_write,
   input  wire logic [acfc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [acfc_pkg::BYTE_W-1:0]         csr_data,
   input  wire logic                                in_accept,
   input  wire logic [acfc_pkg::BYTE_W-1:0]         in_byte,
   output logic                                     push,
   output acfc_pkg::cmd_type                        push_cmd
);

   logic [acfc_pkg::BYTE_W-1:0] start_char_ff;
   logic [acfc_pkg::BYTE_W-1:0] end_char_ff;
   logic                        in_frame_ff;
   logic                        in_frame_in;

   // Configuration registers; unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         start_char_ff <= acfc_pkg::START_CHAR_RESET;
         end_char_ff   <= acfc_pkg::END_CHAR_RESET;
      end else if (csr_write) begin
         if (csr_index == acfc_pkg::CSR_START_CHAR) begin
            start_char_ff <= csr_data;
         end
         if (csr_index == acfc_pkg::CSR_END_CHAR) begin
            end_char_ff <= csr_data;
         end
      end
   end

   // Classify each accepted item against the frame state.
   always_comb begin
      in_frame_in   = in_frame_ff;
      push          = 1'b0;
      push_cmd.op   = acfc_pkg::OP_DATA;
      push_cmd.data = in_byte;
      if (in_accept) begin
         if (!in_frame_ff) begin
            if (in_byte == start_char_ff) begin
               in_frame_in = 1'b1;
               push        = 1'b1;
               push_cmd.op = acfc_pkg::OP_START;
            end
         end else if (in_byte == end_char_ff) begin
            in_frame_in = 1'b0;
            push        = 1'b1;
            push_cmd.op = acfc_pkg::OP_END;
         end else begin
            push        = 1'b1;
            push_cmd.op = acfc_pkg::OP_DATA;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
      end else begin
         in_frame_ff <= in_frame_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/acfc_queue.sv @@
// Short command queue between the front and the back.
`default_nettype none

module acfc_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire acfc_pkg::cmd_type push_cmd,
   input  wire logic              pop,
   output logic                   full,
   output logic                   not_empty,
   output acfc_pkg::cmd_type      head_cmd
);

   acfc_pkg::cmd_type                entry_ff [acfc_pkg::QUEUE_DEPTH];
   logic [acfc_pkg::QPTR_W-1:0]      wr_ptr_ff;
   logic [acfc_pkg::QPTR_W-1:0]      rd_ptr_ff;
   logic [acfc_pkg::QCNT_W-1:0]      count_ff;
   logic [acfc_pkg::QCNT_W-1:0]      count_in;

   assign full      = (count_ff == acfc_pkg::QCNT_W'(acfc_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_cmd  = entry_ff[rd_ptr_ff];

   // Occupancy follows pushes and pops.
   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

@@ rtl/acfc_back.sv @@
// Back end: tail delay line, running CRC, length count and result register.
`default_nettype none

module acfc_back #(
   parameter int MAX_FRAME_LEN = 8192
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                cmd_valid,
   input  wire acfc_pkg::cmd_type                   cmd,
   output logic                                     cmd_pop,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic                                     rsp_out_kind,
   output logic [acfc_pkg::BYTE_W-1:0]              rsp_payload_byte,
   output logic [acfc_pkg::STATUS_W-1:0]            rsp_frame_status,
   output logic [acfc_pkg::LEN_W-1:0]               rsp_frame_length,
   output logic [acfc_pkg::CRC_W-1:0]               rsp_computed_crc
);

   localparam int CNT_W = $clog2(MAX_FRAME_LEN + 1);
   localparam int EXT_W = CNT_W + acfc_pkg::LEN_W;

   logic [acfc_pkg::BYTE_W-1:0]   tail_ff [acfc_pkg::TAIL_LEN];
   logic [acfc_pkg::FILL_W-1:0]   fill_ff;
   logic [acfc_pkg::FILL_W-1:0]   fill_in;
   logic [acfc_pkg::CRC_W-1:0]    crc_ff;
   logic [acfc_pkg::CRC_W-1:0]    crc_in;
   logic [CNT_W-1:0]              count_ff;
   logic [CNT_W-1:0]              count_in;
   logic                          overflow_ff;
   logic                          overflow_in;
   logic                          shift;
   logic                          tail_full;
   logic                          mismatch;
   logic [EXT_W-1:0]              count_ext;
   acfc_pkg::status_type          status;

   logic                          out_valid_ff;
   logic                          out_valid_in;
   logic                          out_kind_ff;
   logic                          out_kind_in;
   logic [acfc_pkg::BYTE_W-1:0]   out_byte_ff;
   logic [acfc_pkg::BYTE_W-1:0]   out_byte_in;
   logic [acfc_pkg::STATUS_W-1:0] out_status_ff;
   logic [acfc_pkg::STATUS_W-1:0] out_status_in;
   logic [acfc_pkg::LEN_W-1:0]    out_len_ff;
   logic [acfc_pkg::LEN_W-1:0]    out_len_in;
   logic [acfc_pkg::CRC_W-1:0]    out_crc_ff;
   logic [acfc_pkg::CRC_W-1:0]    out_crc_in;

   // A command is taken whenever the result register is free or being drained.
   assign cmd_pop   = cmd_valid && (!out_valid_ff || !rsp_stall);
   assign tail_full = (fill_ff == acfc_pkg::FILL_W'(acfc_pkg::TAIL_LEN));
   assign count_ext = EXT_W'(count_ff);

   // Compare the eight newest tail bytes with the CRC in lowercase hex.
   always_comb begin
      mismatch = 1'b0;
      for (int i = 0; i < acfc_pkg::HEX_DIGITS; i++) begin
         if (tail_ff[1 + i] != acfc_pkg::hex_lower(crc_ff[31 - 4 * i -: 4])) begin
            mismatch = 1'b1;
         end
      end
   end

   // Verdict priority: overflow, then too short, then the digit check.
   always_comb begin
      if (overflow_ff) begin
         status = acfc_pkg::STATUS_OVERFLOW;
      end else if (count_ff < CNT_W'(acfc_pkg::TAIL_LEN) || !tail_full) begin
         status = acfc_pkg::STATUS_SHORT;
      end else if (mismatch) begin
         status = acfc_pkg::STATUS_MISMATCH;
      end else begin
         status = acfc_pkg::STATUS_OK;
      end
   end

   // Frame state update and result formation for the command at the head.
   always_comb begin
      fill_in       = fill_ff;
      crc_in        = crc_ff;
      count_in      = count_ff;
      overflow_in   = overflow_ff;
      shift         = 1'b0;
      out_valid_in  = out_valid_ff && rsp_stall;
      out_kind_in   = out_kind_ff;
      out_byte_in   = out_byte_ff;
      out_status_in = out_status_ff;
      out_len_in    = out_len_ff;
      out_crc_in    = out_crc_ff;
      if (cmd_pop) begin
         case (cmd.op)
            acfc_pkg::OP_START: begin
               fill_in     = '0;
               crc_in      = '0;
               count_in    = '0;
               overflow_in = 1'b0;
            end
            acfc_pkg::OP_DATA: begin
               shift = 1'b1;
               if (count_ff == CNT_W'(MAX_FRAME_LEN)) begin
                  overflow_in = 1'b1;
               end else begin
                  count_in = count_ff + 1'b1;
               end
               if (tail_full) begin
                  crc_in        = acfc_pkg::crc32_byte(crc_ff, tail_ff[0]);
                  out_valid_in  = 1'b1;
                  out_kind_in   = acfc_pkg::KIND_PAYLOAD;
                  out_byte_in   = tail_ff[0];
                  out_status_in = '0;
                  out_len_in    = '0;
                  out_crc_in    = '0;
               end else begin
                  fill_in = fill_ff + 1'b1;
               end
            end
            acfc_pkg::OP_END: begin
               out_valid_in  = 1'b1;
               out_kind_in   = acfc_pkg::KIND_VERDICT;
               out_byte_in   = '0;
               out_status_in = status;
               out_len_in    = count_ext[acfc_pkg::LEN_W-1:0];
               out_crc_in    = crc_ff;
            end
            default: begin
               fill_in = fill_ff;
            end
         endcase
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         crc_ff       <= '0;
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         crc_ff       <= crc_in;
         count_ff     <= count_in;
         overflow_ff  <= overflow_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Tail delay line: the oldest byte sits at position zero once full.
   always_ff @(posedge clock) begin
      if (shift) begin
         for (int i = 0; i < acfc_pkg::TAIL_LEN - 1; i++) begin
            tail_ff[i] <= tail_ff[i + 1];
         end
         tail_ff[acfc_pkg::TAIL_LEN - 1] <= cmd.data;
      end
   end

   // Result payload register.
   always_ff @(posedge clock) begin
      out_kind_ff   <= out_kind_in;
      out_byte_ff   <= out_byte_in;
      out_status_ff <= out_status_in;
      out_len_ff    <= out_len_in;
      out_crc_ff    <= out_crc_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_out_kind     = out_kind_ff;
   assign rsp_payload_byte = out_byte_ff;
   assign rsp_frame_status = out_status_ff;
   assign rsp_frame_length = out_len_ff;
   assign rsp_computed_crc = out_crc_ff;

endmodule

`default_nettype wire

@@ rtl/ascii_frame_crc32_checker_top.sv @@
// Top level of the ASCII frame CRC-32 checker.
// The block takes one received byte per item and sustains one item per clock
// while rsp_stall is low; the back end folds a whole byte into the reflected
// CRC-32 (polynomial 0xEDB88320, initial value zero, no final inversion) as
// one combinational update, and that byte update sets the rate. An accepted
// item is classified by the front end in the cycle it arrives and written into
// a two-entry queue; the back end pops it from the queue head when the rsp_
// register is free or being drained and loads its result (if any) into the
// rsp_ register at the edge that pops it, so a result passes the queue entry
// and then the rsp_ register. Outside a frame only the start character does
// anything; inside a frame each byte but the end character passes a nine-byte
// delay line, and bytes leaving it are returned as payload items and added to
// the CRC. The end character yields a verdict item carrying status, saturated
// length and the computed CRC, which is checked against the eight held-back
// lowercase hex digits. req_stall rises only when the queue is full, which
// happens when the result side is stalled.
`default_nettype none

module ascii_frame_crc32_checker_top #(
   parameter int MAX_FRAME_LEN = 8192
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_write,
   input  wire logic [acfc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [acfc_pkg::BYTE_W-1:0]         csr_data,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [acfc_pkg::BYTE_W-1:0]         req_rx_byte,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic                                     rsp_out_kind,
   output logic [acfc_pkg::BYTE_W-1:0]              rsp_payload_byte,
   output logic [acfc_pkg::STATUS_W-1:0]            rsp_frame_status,
   output logic [acfc_pkg::LEN_W-1:0]               rsp_frame_length,
   output logic [acfc_pkg::CRC_W-1:0]               rsp_computed_crc
);

   logic              in_accept;
   logic              push;
   acfc_pkg::cmd_type push_cmd;
   logic              pop;
   logic              queue_full;
   logic              queue_not_empty;
   acfc_pkg::cmd_type head_cmd;

   // Input is held off only while the queue is full.
   assign req_stall = queue_full;
   assign in_accept = req_valid && !req_stall;

   acfc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .in_accept (in_accept),
      .in_byte   (req_rx_byte),
      .push      (push),
      .push_cmd  (push_cmd)
   );

   acfc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .pop       (pop),
      .full      (queue_full),
      .not_empty (queue_not_empty),
      .head_cmd  (head_cmd)
   );

   acfc_back #(
      .MAX_FRAME_LEN (MAX_FRAME_LEN)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cmd_valid        (queue_not_empty),
      .cmd              (head_cmd),
      .cmd_pop          (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_kind     (rsp_out_kind),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_frame_status (rsp_frame_status),
      .rsp_frame_length (rsp_frame_length),
      .rsp_computed_crc (rsp_computed_crc)
   );

endmodule

`default_nettype wire
